FILE: rtl/bank_mapper_with_scanline_irq_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bank mapper
// Shared property forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge
`define BMSI_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define BMSI_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bmsi_pkg.sv
// ----------------------------------------------------------------------------
// bmsi_pkg
// Types, command and target codes, and fixed constants of the bank mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmsi_pkg;

    localparam int PRG_RAM_BYTES = 8192;
    localparam int CHR_RAM_BYTES = 8192;
    localparam int PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);
    localparam int CHR_RAM_AW    = $clog2(CHR_RAM_BYTES);

    // request commands
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_CPU_WR  = 3'd0;
    localparam t_cmd CMD_CPU_RD  = 3'd1;
    localparam t_cmd CMD_PPU_RD  = 3'd2;
    localparam t_cmd CMD_PPU_WR  = 3'd3;
    localparam t_cmd CMD_TICK    = 3'd4;

    // memory targets
    typedef logic [2:0] t_target;
    localparam t_target TGT_NONE    = 3'd0;
    localparam t_target TGT_PRG_ROM = 3'd1;
    localparam t_target TGT_PRG_RAM = 3'd2;
    localparam t_target TGT_CHR_ROM = 3'd3;
    localparam t_target TGT_CHR_RAM = 3'd4;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PRG_MASK = 2'd0;
    localparam t_cfg_idx CFG_CHR_MASK = 2'd1;
    localparam t_cfg_idx CFG_CHR_RAM  = 2'd2;

    // 8KB control ranges above 0x8000 (address bits 14..13)
    typedef logic [1:0] t_range;
    localparam t_range RNG_BANK   = 2'd0;
    localparam t_range RNG_MIRROR = 2'd1;
    localparam t_range RNG_LATCH  = 2'd2;
    localparam t_range RNG_IRQ    = 2'd3;

    // address bits 15..13 of the PRG RAM window 0x6000-0x7FFF
    localparam logic [2:0] PRG_RAM_PAGE = 3'b011;

    // interrupt counter clock point
    localparam logic [8:0]        TICK_DOT     = 9'd261;
    localparam logic [8:0]        LAST_VISIBLE = 9'd239;
    localparam logic signed [9:0] IRQ_LINE     = 10'sd260;

    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        bus_addr;
        logic [7:0]         bus_data;
        logic [8:0]         ppu_cycle;
        logic signed [9:0]  ppu_scanline;
    } t_item;

    typedef struct packed {
        logic [7:0] prg_bank_mask;
        logic [7:0] chr_bank_mask;
        logic       chr_ram_used;
    } t_cfg;

    typedef struct packed {
        logic [7:0][7:0] bank_regs;
        logic            prg_mode;
        logic            chr_invert;
        logic            ram_protect;
    } t_bank_state;

    typedef struct packed {
        t_target     target;
        logic [20:0] mem_index;
        logic        mem_write;
        logic        mirror_horizontal;
        logic        irq_pulse;
    } t_result;

endpackage

FILE: rtl/bmsi_regs.sv
// ----------------------------------------------------------------------------
// bmsi_regs
// Configuration, bank control registers and the scanline interrupt counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsi_regs (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  bmsi_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  logic                   i_adv,
    input  bmsi_pkg::t_item        i_item,
    output bmsi_pkg::t_cfg         o_cfg,
    output bmsi_pkg::t_bank_state  o_bank,
    output logic                   o_mirror,
    output logic                   o_irq_pulse
);
    import bmsi_pkg::*;

    t_cfg            r_cfg;
    logic [7:0][7:0] r_bank_regs;
    logic [2:0]      r_bank_index;
    logic            r_prg_mode;
    logic            r_chr_invert;
    logic            r_mirror;
    logic            r_ram_protect;
    logic [7:0]      r_reload;
    logic [7:0]      r_counter;
    logic            r_pending;
    logic            r_irq_on;

    logic            ctrl_wr;
    logic            odd;
    t_range          rng;
    logic            line_hit;
    logic            tick;
    logic [7:0]      n_counter;
    logic [7:0]      bank_wdata;

    assign odd  = i_item.bus_addr[0];
    assign rng  = i_item.bus_addr[14:13];
    assign ctrl_wr = i_adv && (i_item.cmd == CMD_CPU_WR) && i_item.bus_addr[15];

    assign line_hit = (!i_item.ppu_scanline[9] && (i_item.ppu_scanline[8:0] <= LAST_VISIBLE))
                      || (i_item.ppu_scanline == IRQ_LINE);
    assign tick = i_adv && (i_item.cmd == CMD_TICK) && (i_item.ppu_cycle == TICK_DOT)
                  && line_hit;

    // reload on zero or pending reload, else count down
    assign n_counter = ((r_counter == 8'd0) || r_pending) ? r_reload : r_counter - 8'd1;

    // bank registers 0 and 1 hold even 2KB pairs
    assign bank_wdata = (r_bank_index < 3'd2) ? {i_item.bus_data[7:1], 1'b0}
                                              : i_item.bus_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_bank_mask <= 8'd1;
            r_cfg.chr_bank_mask <= 8'd7;
            r_cfg.chr_ram_used  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PRG_MASK: r_cfg.prg_bank_mask <= i_cfg_data;
                CFG_CHR_MASK: r_cfg.chr_bank_mask <= i_cfg_data;
                CFG_CHR_RAM:  r_cfg.chr_ram_used  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_regs   <= '0;
            r_bank_index  <= '0;
            r_prg_mode    <= 1'b0;
            r_chr_invert  <= 1'b0;
            r_mirror      <= 1'b0;
            r_ram_protect <= 1'b0;
            r_reload      <= '0;
            r_counter     <= '0;
            r_pending     <= 1'b0;
            r_irq_on      <= 1'b0;
        end else begin
            if (ctrl_wr) begin
                unique case (rng)
                    RNG_BANK: begin
                        if (!odd) begin
                            r_bank_index <= i_item.bus_data[2:0];
                            r_prg_mode   <= i_item.bus_data[6];
                            r_chr_invert <= i_item.bus_data[7];
                        end else begin
                            r_bank_regs[r_bank_index] <= bank_wdata;
                        end
                    end
                    RNG_MIRROR: begin
                        if (!odd) begin
                            r_mirror <= i_item.bus_data[0];
                        end else begin
                            r_ram_protect <= i_item.bus_data[6];
                        end
                    end
                    RNG_LATCH: begin
                        if (!odd) begin
                            r_reload <= i_item.bus_data;
                        end else begin
                            r_pending <= 1'b1;
                            r_counter <= '0;
                        end
                    end
                    RNG_IRQ: r_irq_on <= odd;
                    default: ;
                endcase
            end
            if (tick) begin
                r_counter <= n_counter;
                r_pending <= 1'b0;
            end
        end
    end

    assign o_cfg              = r_cfg;
    assign o_bank.bank_regs   = r_bank_regs;
    assign o_bank.prg_mode    = r_prg_mode;
    assign o_bank.chr_invert  = r_chr_invert;
    assign o_bank.ram_protect = r_ram_protect;

    // the result shows mirroring as this request leaves it
    assign o_mirror = (ctrl_wr && (rng == RNG_MIRROR) && !odd) ? i_item.bus_data[0] : r_mirror;
    assign o_irq_pulse = tick && (n_counter == 8'd0) && r_irq_on;

endmodule

FILE: rtl/bmsi_map.sv
// ----------------------------------------------------------------------------
// bmsi_map
// Address translation of CPU and PPU accesses to target memory and index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmsi_map (
    input  bmsi_pkg::t_item        i_item,
    input  bmsi_pkg::t_cfg         i_cfg,
    input  bmsi_pkg::t_bank_state  i_bank,
    output bmsi_pkg::t_target      o_target,
    output logic [20:0]            o_mem_index,
    output logic                   o_mem_write
);
    import bmsi_pkg::*;

    logic [15:0] addr;
    logic        prg_ram_hit;
    logic [1:0]  prg_win;
    logic [7:0]  second_last;
    logic [7:0]  prg_bank;
    logic [20:0] prg_index;
    logic [2:0]  chr_win;
    logic [2:0]  chr_reg;
    logic [7:0]  chr_bank;
    logic [20:0] chr_index;
    logic [20:0] prg_ram_index;
    logic [20:0] chr_ram_index;

    assign addr        = i_item.bus_addr;
    assign prg_ram_hit = (addr[15:13] == PRG_RAM_PAGE);
    assign prg_ram_index = {{(21 - PRG_RAM_AW){1'b0}}, addr[PRG_RAM_AW-1:0]};
    assign chr_ram_index = {{(21 - CHR_RAM_AW){1'b0}}, addr[CHR_RAM_AW-1:0]};

    // PRG: 8KB windows, two fixed to the top banks
    assign prg_win     = addr[14:13];
    assign second_last = i_cfg.prg_bank_mask - 8'd1;
    always_comb begin
        case (prg_win)
            2'd0:    prg_bank = i_bank.prg_mode ? second_last : i_bank.bank_regs[6];
            2'd1:    prg_bank = i_bank.bank_regs[7];
            2'd2:    prg_bank = i_bank.prg_mode ? i_bank.bank_regs[6] : second_last;
            default: prg_bank = i_cfg.prg_bank_mask;
        endcase
    end
    assign prg_index = {prg_bank & i_cfg.prg_bank_mask, addr[12:0]};

    // CHR: 1KB windows, lower half from the 2KB pairs R0/R1, upper from R2..R5
    assign chr_win = addr[12:10] ^ {i_bank.chr_invert, 2'b00};
    assign chr_reg = chr_win[2] ? (chr_win - 3'd2) : {2'b00, chr_win[1]};
    assign chr_bank = i_bank.bank_regs[chr_reg] + {7'd0, (!chr_win[2] && chr_win[0])};
    assign chr_index = {3'd0, chr_bank & i_cfg.chr_bank_mask, addr[9:0]};

    always_comb begin
        o_target    = TGT_NONE;
        o_mem_index = '0;
        o_mem_write = 1'b0;
        case (i_item.cmd)
            CMD_CPU_WR: begin
                if (prg_ram_hit) begin
                    o_target    = TGT_PRG_RAM;
                    o_mem_index = prg_ram_index;
                    o_mem_write = !i_bank.ram_protect;
                end
            end
            CMD_CPU_RD: begin
                if (prg_ram_hit) begin
                    o_target    = TGT_PRG_RAM;
                    o_mem_index = prg_ram_index;
                end else if (addr[15]) begin
                    o_target    = TGT_PRG_ROM;
                    o_mem_index = prg_index;
                end
            end
            CMD_PPU_RD: begin
                if (i_cfg.chr_ram_used) begin
                    o_target    = TGT_CHR_RAM;
                    o_mem_index = chr_ram_index;
                end else if (addr[15:13] == 3'b000) begin
                    o_target    = TGT_CHR_ROM;
                    o_mem_index = chr_index;
                end
            end
            CMD_PPU_WR: begin
                if (i_cfg.chr_ram_used) begin
                    o_target    = TGT_CHR_RAM;
                    o_mem_index = chr_ram_index;
                    o_mem_write = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/bank_mapper_with_scanline_irq.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq
// Cartridge bank mapper: translates CPU/PPU accesses, holds the bank control
// registers and clocks a scanline interrupt counter.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tuser: cmd; tdata: addr, data, dot, line
//  m_axis    out        tvalid/tready          tuser: target; tdata: index, flags
//  cfg       in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
//  One request per cycle sustained while results are taken; a request passes
//  from acceptance through the input register, then the result register.
//  Translation and the control register update happen in the single step
//  between them, so each request sees every earlier request's effect.
//  Reset (synchronous, active low) empties both registers and restores the
//  control state and configuration defaults.
//  A stalled result holds in the result register while the input register
//  still takes one more request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  bmsi_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [7:0]                 i_cfg_data,
    // request stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [47:0]                s_axis_tdata,  // bus_addr, bus_data, ppu_cycle, ppu_scanline
    input  logic [2:0]                 s_axis_tuser,  // cmd
    // result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // mem_index, mem_write, mirror_horizontal, irq_pulse
    output logic [2:0]                 m_axis_tuser   // target
);
    import bmsi_pkg::*;

    logic        r_in_vld;
    t_item       r_in;
    logic        r_out_vld;
    t_result     r_out;

    logic        adv;
    t_cfg        cfg;
    t_bank_state bank;
    logic        mirror;
    logic        irq_pulse;
    t_target     target;
    logic [20:0] mem_index;
    logic        mem_write;

    // advance the held request whenever the result register is free or draining
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    // input register: capture a request, drop it once it advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd          <= s_axis_tuser;
            r_in.bus_addr     <= s_axis_tdata[15:0];
            r_in.bus_data     <= s_axis_tdata[23:16];
            r_in.ppu_cycle    <= s_axis_tdata[32:24];
            r_in.ppu_scanline <= s_axis_tdata[42:33];
        end
    end

    bmsi_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (adv),
        .i_item      (r_in),
        .o_cfg       (cfg),
        .o_bank      (bank),
        .o_mirror    (mirror),
        .o_irq_pulse (irq_pulse)
    );

    // translation sees the control state from before this request's own write
    bmsi_map u_map (
        .i_item      (r_in),
        .i_cfg       (cfg),
        .i_bank      (bank),
        .o_target    (target),
        .o_mem_index (mem_index),
        .o_mem_write (mem_write)
    );

    // result register: load on advance, release when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.target            <= target;
            r_out.mem_index         <= mem_index;
            r_out.mem_write         <= mem_write;
            r_out.mirror_horizontal <= mirror;
            r_out.irq_pulse         <= irq_pulse;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.target;
    assign m_axis_tdata  = {r_out.irq_pulse, r_out.mirror_horizontal, r_out.mem_write,
                            r_out.mem_index};

endmodule

FILE: rtl/bmsi_chk.sv
// ----------------------------------------------------------------------------
// bmsi_chk
// Port-level checker for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bank_mapper_with_scanline_irq_assert.svh"

module bmsi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import bmsi_pkg::*;

    `BMSI_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid, "result valid after reset")
    `BMSI_ASSERT_NXT(a_stall_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `BMSI_ASSERT_IMP(a_none_clean, i_clk, !i_rst_n, m_axis_tvalid && (m_axis_tuser == TGT_NONE), (m_axis_tdata[21:0] == 22'd0), "no target but index or write set")
    `BMSI_ASSERT_IMP(a_irq_tick, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tdata[23], (m_axis_tuser == TGT_NONE), "interrupt on a memory access")
    `BMSI_ASSERT_IMP(a_write_ram, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tdata[21], (m_axis_tuser == TGT_PRG_RAM) || (m_axis_tuser == TGT_CHR_RAM), "write to a non-RAM target")

endmodule

bind bank_mapper_with_scanline_irq bmsi_chk u_bmsi_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/bank_mapper_with_scanline_irq_test.sv
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_test
// Self-checking bench for the cartridge bank mapper. It streams CPU/PPU
// requests and scanline ticks into the block and mirrors its banking, RAM
// protect, mirroring and interrupt counter in a scoreboard. Each result is
// checked field by field against the scoreboard's prediction while both
// stream sides idle and stall in several pacing phases and the configuration
// moves through its extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_test;

    import bmsi_pkg::*;

    // Command codes above the tick are reserved and ignored by the mapper.
    localparam t_cmd CMD_RESERVED = 3'd7;

    // Bus pacing per phase.
    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    localparam int NUM_PHASES      = 8;
    localparam int REQS_PER_PHASE  = 146;

    // Mask settings per phase; phase 4 draws its own at random.
    localparam logic [7:0] PRG_MASK_TBL [NUM_PHASES] =
        '{8'd1, 8'd255, 8'd1, 8'd31, 8'd1, 8'd3, 8'd255, 8'd127};
    localparam logic [7:0] CHR_MASK_TBL [NUM_PHASES] =
        '{8'd7, 8'd255, 8'd0, 8'd127, 8'd0, 8'd15, 8'd0, 8'd63};
    localparam logic       CHR_RAM_TBL  [NUM_PHASES] =
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    // ------------------------------------------------------------------------
    // Mapper scoreboard: shadow of the control state plus the queue of
    // results that accepted requests still owe.
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        t_cfg       cfg;
        logic [7:0] bank_regs [8];
        logic [2:0] bank_sel;
        logic       prg_mode;
        logic       chr_invert;
        logic       mirror_h;
        logic       ram_protect;
        logic [7:0] reload_value;
        logic [7:0] line_counter;
        logic       reload_pending;
        logic       irq_on;
        t_result    owed_results [$];
        int         errors;

        function void power_on();
            cfg = '{prg_bank_mask: 8'd1, chr_bank_mask: 8'd7, chr_ram_used: 1'b0};
            foreach (bank_regs[i]) bank_regs[i] = '0;
            bank_sel       = '0;
            prg_mode       = 1'b0;
            chr_invert     = 1'b0;
            mirror_h       = 1'b0;
            ram_protect    = 1'b0;
            reload_value   = '0;
            line_counter   = '0;
            reload_pending = 1'b0;
            irq_on         = 1'b0;
            owed_results.delete();
            errors         = 0;
        endfunction

        function void set_config(t_cfg value);
            cfg = value;
        endfunction

        // 8KB PRG windows: the two swappable slots trade places with prg_mode.
        function logic [20:0] prg_rom_offset(logic [15:0] addr);
            logic [7:0] bank;
            case (addr[14:13])
                2'd0:    bank = prg_mode ? cfg.prg_bank_mask - 8'd1 : bank_regs[6];
                2'd1:    bank = bank_regs[7];
                2'd2:    bank = prg_mode ? bank_regs[6] : cfg.prg_bank_mask - 8'd1;
                default: bank = cfg.prg_bank_mask;
            endcase
            bank &= cfg.prg_bank_mask;
            return {bank, addr[12:0]};
        endfunction

        // 1KB CHR windows; inversion swaps the 2KB and 1KB halves.
        function logic [20:0] chr_rom_offset(logic [15:0] addr);
            logic [2:0] win;
            logic [7:0] bank;
            win = addr[12:10] ^ {chr_invert, 2'b00};
            if (!win[2]) begin
                bank = bank_regs[{2'b00, win[1]}] + {7'b0, win[0]};
            end else begin
                bank = bank_regs[win - 3'd2];
            end
            bank &= cfg.chr_bank_mask;
            return {3'b000, bank, addr[9:0]};
        endfunction

        function void control_write(logic [15:0] addr, logic [7:0] data);
            case (t_range'(addr[14:13]))
                RNG_BANK: begin
                    if (!addr[0]) begin
                        bank_sel   = data[2:0];
                        prg_mode   = data[6];
                        chr_invert = data[7];
                    end else begin
                        // 2KB registers drop their low bit
                        bank_regs[bank_sel] = (bank_sel < 3'd2) ? (data & 8'hFE) : data;
                    end
                end
                RNG_MIRROR: begin
                    if (!addr[0]) mirror_h = data[0];
                    else ram_protect = data[6];
                end
                RNG_LATCH: begin
                    if (!addr[0]) begin
                        reload_value = data;
                    end else begin
                        reload_pending = 1'b1;
                        line_counter   = '0;
                    end
                end
                default: irq_on = addr[0];
            endcase
        endfunction

        // Advance the shadow state by one request and return its result.
        function t_result apply_request(t_item req);
            t_result res;
            int      line;
            res  = '0;
            line = int'(req.ppu_scanline);
            case (req.cmd)
                CMD_CPU_WR: begin
                    if (req.bus_addr[15:13] == PRG_RAM_PAGE) begin
                        res.target    = TGT_PRG_RAM;
                        res.mem_index = {8'b0, req.bus_addr[12:0]};
                        res.mem_write = !ram_protect;
                    end else if (req.bus_addr[15]) begin
                        control_write(req.bus_addr, req.bus_data);
                    end
                end
                CMD_CPU_RD: begin
                    if (req.bus_addr[15:13] == PRG_RAM_PAGE) begin
                        res.target    = TGT_PRG_RAM;
                        res.mem_index = {8'b0, req.bus_addr[12:0]};
                    end else if (req.bus_addr[15]) begin
                        res.target    = TGT_PRG_ROM;
                        res.mem_index = prg_rom_offset(req.bus_addr);
                    end
                end
                CMD_PPU_RD: begin
                    if (cfg.chr_ram_used) begin
                        res.target    = TGT_CHR_RAM;
                        res.mem_index = {8'b0, req.bus_addr[12:0]};
                    end else if (req.bus_addr[15:13] == 3'b000) begin
                        res.target    = TGT_CHR_ROM;
                        res.mem_index = chr_rom_offset(req.bus_addr);
                    end
                end
                CMD_PPU_WR: begin
                    if (cfg.chr_ram_used) begin
                        res.target    = TGT_CHR_RAM;
                        res.mem_index = {8'b0, req.bus_addr[12:0]};
                        res.mem_write = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (req.ppu_cycle == TICK_DOT &&
                        ((line >= 0 && line <= int'(LAST_VISIBLE)) || line == int'(IRQ_LINE))) begin
                        if (line_counter == 8'd0 || reload_pending) begin
                            line_counter   = reload_value;
                            reload_pending = 1'b0;
                        end else begin
                            line_counter = line_counter - 8'd1;
                        end
                        res.irq_pulse = (line_counter == 8'd0) && irq_on;
                    end
                end
                default: ;
            endcase
            res.mirror_horizontal = mirror_h;
            return res;
        endfunction

        function void note_request(t_item req);
            owed_results.push_back(apply_request(req));
        endfunction

        function void check_result(t_target tgt, logic [23:0] payload);
            t_result want;
            if (owed_results.size() == 0) begin
                $error("result with no request outstanding: target %0d index 0x%0h",
                       tgt, payload[20:0]);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (tgt !== want.target) begin
                $error("target: expected %0d, got %0d", want.target, tgt);
                errors++;
            end
            if (payload[20:0] !== want.mem_index) begin
                $error("mem_index: expected 0x%0h, got 0x%0h", want.mem_index, payload[20:0]);
                errors++;
            end
            if (payload[21] !== want.mem_write) begin
                $error("mem_write: expected %0b, got %0b", want.mem_write, payload[21]);
                errors++;
            end
            if (payload[22] !== want.mirror_horizontal) begin
                $error("mirror_horizontal: expected %0b, got %0b",
                       want.mirror_horizontal, payload[22]);
                errors++;
            end
            if (payload[23] !== want.irq_pulse) begin
                $error("irq_pulse: expected %0b, got %0b", want.irq_pulse, payload[23]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals: every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    t_cfg_idx    i_cfg_idx     = CFG_PRG_MASK;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // bus_addr, bus_data, ppu_cycle, ppu_scanline
    logic [2:0]  s_axis_tuser  = '0;  // cmd
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;        // mem_index, mem_write, mirror_horizontal, irq_pulse
    wire  [2:0]  m_axis_tuser;        // target

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    mapper_scoreboard sb;

    bank_mapper_with_scanline_irq u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: redraw the stall at every falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check every result on the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(t_target'(m_axis_tuser), m_axis_tdata);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    function automatic t_item make_request(t_cmd cmd, logic [15:0] addr, logic [7:0] data,
                                           logic [8:0] dot, int line);
        t_item req;
        req.cmd          = cmd;
        req.bus_addr     = addr;
        req.bus_data     = data;
        req.ppu_cycle    = dot;
        req.ppu_scanline = 10'(line);
        return req;
    endfunction

    // Present one request, idling first at the current rate, and hold it
    // until the block takes it.
    task automatic issue_request(input t_item req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, req.ppu_scanline, req.ppu_cycle, req.bus_data, req.bus_addr};
        s_axis_tuser  <= req.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed result is back, then settle.
    task automatic wait_results_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write all three registers on consecutive edges; the block is idle here.
    task automatic program_config(input logic [7:0] prg_m, input logic [7:0] chr_m,
                                  input logic ram_m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PRG_MASK;
        i_cfg_data <= prg_m;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_CHR_MASK;
        i_cfg_data <= chr_m;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_CHR_RAM;
        i_cfg_data <= {7'b0, ram_m};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config('{prg_bank_mask: prg_m, chr_bank_mask: chr_m, chr_ram_used: ram_m});
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 81; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default:         begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // Short walk through the register map and the corner cases, on the
    // reset configuration.
    task automatic run_directed();
        t_item seq [$];
        // bank select R6 with swapped PRG mode and CHR inversion, then fill R6
        seq.push_back(make_request(CMD_CPU_WR, 16'h8000, 8'hC6, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'h8001, 8'hFF, 9'd0, 0));
        // R0 and R1 lose their low bit
        seq.push_back(make_request(CMD_CPU_WR, 16'h9FFE, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'h8001, 8'hFF, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'h8000, 8'h01, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'h8001, 8'h01, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_RD, 16'h8000, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_RD, 16'hFFFF, 8'h00, 9'd0, 0));
        // PRG RAM writable, then protected; chip enable bit is ignored
        seq.push_back(make_request(CMD_CPU_WR, 16'h6000, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'hA001, 8'hC0, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'h7FFF, 8'hFF, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'hA000, 8'h01, 9'd0, 0));
        // below PRG RAM: nothing addressed
        seq.push_back(make_request(CMD_CPU_RD, 16'h0000, 8'h00, 9'd0, 0));
        // CHR ROM reads, read above pattern space, write to ROM
        seq.push_back(make_request(CMD_PPU_RD, 16'h0000, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_PPU_RD, 16'h1FFF, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_PPU_RD, 16'h2000, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_PPU_WR, 16'h1000, 8'h5A, 9'd0, 0));
        seq.push_back(make_request(CMD_RESERVED, 16'hFFFF, 8'hFF, 9'd511, -1));
        // zero latch, reload, enable: every counter clock fires
        seq.push_back(make_request(CMD_CPU_WR, 16'hC000, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'hC001, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_CPU_WR, 16'hE001, 8'h00, 9'd0, 0));
        seq.push_back(make_request(CMD_TICK, 16'h0000, 8'h00, TICK_DOT, 0));
        seq.push_back(make_request(CMD_TICK, 16'h0000, 8'h00, TICK_DOT, 260));
        // prerender line leaves the counter alone, then the interrupt is disabled
        seq.push_back(make_request(CMD_TICK, 16'h0000, 8'h00, TICK_DOT, -1));
        seq.push_back(make_request(CMD_CPU_WR, 16'hE000, 8'h00, 9'd0, 0));
        foreach (seq[i]) issue_request(seq[i]);
    endtask

    // Random request weighted toward control writes and counter clocks so
    // the interrupt path is exercised; the rest is bus traffic and noise.
    function automatic t_item random_request();
        t_item req;
        int    pick;
        req.cmd          = CMD_CPU_WR;
        req.bus_addr     = 16'($urandom);
        req.bus_data     = 8'($urandom);
        req.ppu_cycle    = 9'($urandom);
        req.ppu_scanline = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            req.bus_addr[15] = 1'b1;
            if (req.bus_addr[14:13] == RNG_IRQ) begin
                req.bus_addr[0] = ($urandom_range(0, 3) != 0);
            end
            // keep the latch small so the counter reaches zero often
            if (req.bus_addr[14:13] == RNG_LATCH && !req.bus_addr[0] &&
                $urandom_range(0, 3) != 0) begin
                req.bus_data = 8'($urandom_range(0, 6));
            end
        end else if (pick < 40) begin
            req.cmd = CMD_CPU_WR;
        end else if (pick < 55) begin
            req.cmd = CMD_CPU_RD;
            if ($urandom_range(0, 3) != 0) req.bus_addr[15:13] = 3'($urandom_range(3, 7));
        end else if (pick < 65) begin
            req.cmd = CMD_PPU_RD;
            if ($urandom_range(0, 3) != 0) req.bus_addr[15:13] = 3'b000;
        end else if (pick < 70) begin
            req.cmd = CMD_PPU_WR;
        end else if (pick < 95) begin
            req.cmd = CMD_TICK;
            if ($urandom_range(0, 4) != 0) begin
                req.ppu_cycle    = TICK_DOT;
                req.ppu_scanline = ($urandom_range(0, 9) == 0) ? IRQ_LINE
                                   : 10'($urandom_range(0, int'(LAST_VISIBLE)));
            end else if ($urandom_range(0, 1) != 0) begin
                req.ppu_cycle = TICK_DOT;
            end
        end else begin
            req.cmd = t_cmd'($urandom_range(int'(CMD_TICK) + 1, int'(CMD_RESERVED)));
        end
        return req;
    endfunction

    task automatic run_random(input int count, input bit pause_midway);
        int    done;
        t_item req;
        done = 0;
        while (done < count) begin
            req = random_request();
            issue_request(req);
            if (req.cmd <= CMD_TICK) done++;
            // hold the sender once until the pipeline is empty
            if (pause_midway && done == count / 2) begin
                wait_results_drained(0);
                pause_midway = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed walk, then paced random phases, each on
    // its own configuration.
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] prg_m;
        logic [7:0] chr_m;
        logic       ram_m;
        sb = new();
        sb.power_on();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_pace(PACE_FULL);
        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // block must be idle before the configuration changes
            wait_results_drained(4);
            prg_m = PRG_MASK_TBL[p];
            chr_m = CHR_MASK_TBL[p];
            ram_m = CHR_RAM_TBL[p];
            if (p == 4) begin
                prg_m = 8'($urandom_range(1, 255));
                chr_m = 8'($urandom_range(0, 255));
                ram_m = 1'($urandom_range(0, 1));
            end
            program_config(prg_m, chr_m, ram_m);
            set_pace(t_pace'(p % 4));
            run_random(REQS_PER_PHASE, p == 3);
        end

        wait_results_drained(8);
        if (sb.errors == 0 && sb.owed_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
